// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it
`define LSEV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion lbl failed");

// Implication helper built on the one above
`define LSEV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `LSEV_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== rtl/core/lsev_pkg.sv =====
// Package: constants, types and helpers of the Legendre series evaluator
`timescale 1ns / 1ps
package lsev_pkg;

  localparam int unsigned MaxOrder  = 31;
  localparam int unsigned OrdW      = 5;
  localparam int unsigned TabDepth  = MaxOrder + 1;
  localparam int unsigned TabAw     = $clog2(TabDepth);
  localparam int unsigned KW        = $clog2(MaxOrder + 2);
  localparam int unsigned CoefW     = 32;
  localparam int unsigned PW        = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned AccW      = 40;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned NumW      = 40;
  localparam int unsigned DivSteps  = 4;
  localparam int unsigned DivCycles = NumW / DivSteps;
  localparam int unsigned DivCntW   = $clog2(DivCycles);
  localparam int unsigned InDataW   = 72;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 96;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 5;

  localparam logic signed [PW-1:0] OneQ30 = 32'sh4000_0000;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ORDER   = 1'b0,
    CFG_FIRST_CLASS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_XP = 2'd0,
    MUL_C0 = 2'd1,
    MUL_C1 = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load_we;
    logic     eval_init;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     t_en;
    logic     acc0_en;
    logic     acc1_en;
    logic     num_en;
    logic     p_upd;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_last;
    logic div_done;
  } dp_sts_t;

  // Q.30 rounding, halves away from zero
  function automatic logic signed [33:0] rnd_q30(input logic signed [ProdW-1:0] v);
    logic [ProdW-1:0] mag;
    logic [33:0]      r;
    mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    r   = 34'((mag + (64'd1 << 29)) >> 30);
    return v[ProdW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== rtl/core/legendre_series_evaluator_core.sv =====
// Top level of the Legendre series evaluator
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: order, coeff, arg; tuser: op, class
//   m_axis    out  tvalid/tready         tdata: small sum, large sum
//   cfg       in   cfg_we_i              cfg_idx_i, cfg_data_i
// A load writes its coefficient and leaves the input ready. An evaluate steps each
// order through S_MXP, S_MC0, S_MC1 and S_ACC on the single shared 32x32 multiplier;
// orders after the first and before the last then run a 4-bit-per-cycle divide. The
// result sits in an output register; the next item is taken while it waits, and a
// stalled result holds a following evaluate in its last state.
// Reset: max_order 31, first_pmt_class 0; coefficient tables are not cleared.
`timescale 1ns / 1ps
module legendre_series_evaluator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] order_index, [36:5] coeff_value, [68:37] arg_x, [71:69] zero
  input  logic [lsev_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] op, [1] pmt_class
  input  logic [lsev_pkg::InUserW-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [47:0] small_class_sum, [95:48] large_class_sum
  output logic [lsev_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [lsev_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lsev_pkg::CfgDataW-1:0]     cfg_data_i
);
  import lsev_pkg::*;

  logic [OrdW-1:0]        max_order_q;
  logic                   first_class_q;
  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic signed [SumW-1:0] small_sum, large_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_order_q   <= OrdW'(31);
      first_class_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ORDER:   max_order_q   <= cfg_data_i[OrdW-1:0];
        CFG_FIRST_CLASS: first_class_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lsev_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsev_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pmt_class_i   (s_axis_tuser[1]),
    .order_index_i (s_axis_tdata[4:0]),
    .coeff_value_i ($signed(s_axis_tdata[36:5])),
    .arg_x_i       ($signed(s_axis_tdata[68:37])),
    .max_order_i   (max_order_q),
    .first_class_i (first_class_q),
    .small_sum_o   (small_sum),
    .large_sum_o   (large_sum)
  );

  assign m_axis_tdata = {large_sum, small_sum};

endmodule

// ===== rtl/core/lsev_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lsev_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lsev_div.sv =====
// Iterative restoring divider, several quotient bits per cycle
`timescale 1ns / 1ps
module lsev_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsev_pkg::NumW-1:0]   dividend_i,
  input  logic [lsev_pkg::KW-1:0]     divisor_i,
  output logic [lsev_pkg::NumW-1:0]   quot_o,
  output logic                        done_o
);
  import lsev_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [NumW-1:0]     dvd_q, dvd_d;
  logic [KW:0]         rem_q, rem_d;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int i = 0; i < DivSteps; i++) begin
      rem_d = {rem_d[KW-1:0], dvd_d[NumW-1]};
      dvd_d = {dvd_d[NumW-2:0], 1'b0};
      if (rem_d >= {1'b0, divisor_i}) begin
        rem_d    = rem_d - {1'b0, divisor_i};
        dvd_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/lsev_dp.sv =====
// Datapath: coefficient tables, shared multiplier, recurrence, sums
`timescale 1ns / 1ps
module lsev_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsev_pkg::dp_cmd_t             cmd_i,
  output lsev_pkg::dp_sts_t             sts_o,
  input  logic                          pmt_class_i,
  input  logic [lsev_pkg::OrdW-1:0]     order_index_i,
  input  logic signed [lsev_pkg::CoefW-1:0] coeff_value_i,
  input  logic signed [lsev_pkg::PW-1:0]    arg_x_i,
  input  logic [lsev_pkg::OrdW-1:0]     max_order_i,
  input  logic                          first_class_i,
  output logic signed [lsev_pkg::SumW-1:0]  small_sum_o,
  output logic signed [lsev_pkg::SumW-1:0]  large_sum_o
);
  import lsev_pkg::*;

  logic signed [PW-1:0]    x_q, p_prev_q, p_cur_q, t_q, p_next;
  logic signed [ProdW-1:0] prod_q;
  logic signed [CoefW-1:0] mul_a;
  logic signed [AccW-1:0]  acc0_q, acc1_q;
  logic signed [SumW-1:0]  small_q, large_q;
  logic [TabAw-1:0]        k_q, n_q;
  logic [CoefW-1:0]        c0_rd, c1_rd;
  logic                    wr_ok, num_neg_q;
  logic [KW-1:0]           k1, half;
  logic [TabAw:0]          k2p1;
  logic signed [NumW-1:0]  t_ext, pp_ext, num, qs;
  logic [NumW-1:0]         mag, quot;
  logic                    div_done;

  assign wr_ok = 32'(order_index_i) <= MaxOrder;

  lsev_ram #(.Width(CoefW), .Depth(TabDepth)) u_ram_small (
    .clk_i,
    .we_i    (cmd_i.load_we && wr_ok && !pmt_class_i),
    .waddr_i (TabAw'(order_index_i)),
    .wdata_i (coeff_value_i),
    .raddr_i (k_q),
    .rdata_o (c0_rd)
  );

  lsev_ram #(.Width(CoefW), .Depth(TabDepth)) u_ram_large (
    .clk_i,
    .we_i    (cmd_i.load_we && wr_ok && pmt_class_i),
    .waddr_i (TabAw'(order_index_i)),
    .wdata_i (coeff_value_i),
    .raddr_i (k_q),
    .rdata_o (c1_rd)
  );

  // recurrence numerator (2k+1)*t - k*P[k-1], then rounding offset for /(k+1)
  assign k2p1   = {k_q, 1'b1};
  assign k1     = KW'(k_q) + KW'(1);
  assign half   = k1 >> 1;
  assign t_ext  = NumW'(t_q);
  assign pp_ext = NumW'(p_prev_q);
  assign num    = t_ext * $signed({1'b0, k2p1}) - pp_ext * $signed({1'b0, k_q});
  assign mag    = (num[NumW-1] ? NumW'(-num) : NumW'(num)) + NumW'(half);

  lsev_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.num_en),
    .dividend_i (mag),
    .divisor_i  (k1),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign qs = num_neg_q ? -$signed(quot) : $signed(quot);

  always_comb begin
    if (k_q == '0) begin
      p_next = x_q;
    end else if (qs > NumW'(OneQ30)) begin
      p_next = OneQ30;
    end else if (qs < -NumW'(OneQ30)) begin
      p_next = -OneQ30;
    end else begin
      p_next = PW'(qs);
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XP:  mul_a = x_q;
      MUL_C0:  mul_a = $signed(c0_rd);
      MUL_C1:  mul_a = $signed(c1_rd);
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_init) begin
      if (arg_x_i > OneQ30) begin
        x_q <= OneQ30;
      end else if (arg_x_i < -OneQ30) begin
        x_q <= -OneQ30;
      end else begin
        x_q <= arg_x_i;
      end
      n_q      <= (32'(max_order_i) > MaxOrder) ? TabAw'(MaxOrder) : TabAw'(max_order_i);
      k_q      <= '0;
      p_prev_q <= '0;
      p_cur_q  <= OneQ30;
      acc0_q   <= '0;
      acc1_q   <= '0;
    end
    if (cmd_i.mul_en) prod_q <= mul_a * p_cur_q;
    if (cmd_i.t_en) t_q <= PW'(rnd_q30(prod_q));
    if (cmd_i.acc0_en) acc0_q <= acc0_q + AccW'(rnd_q30(prod_q));
    if (cmd_i.acc1_en) acc1_q <= acc1_q + AccW'(rnd_q30(prod_q));
    if (cmd_i.num_en) num_neg_q <= num[NumW-1];
    if (cmd_i.p_upd) begin
      p_prev_q <= p_cur_q;
      p_cur_q  <= p_next;
      k_q      <= k_q + TabAw'(1);
    end
    // at most 32 terms of 33 bits: the sum never reaches the 48-bit limits
    if (cmd_i.out_load) begin
      small_q <= first_class_i ? '0 : SumW'(acc0_q);
      large_q <= SumW'(acc1_q);
    end
  end

  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.k_last   = (k_q == n_q);
  assign sts_o.div_done = div_done;
  assign small_sum_o    = small_q;
  assign large_sum_o    = large_q;

endmodule

// ===== rtl/core/lsev_ctrl.sv =====
// Controller: sequences loads, per-order steps and result transfer
`timescale 1ns / 1ps
module lsev_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsev_pkg::dp_cmd_t cmd_o,
  input  lsev_pkg::dp_sts_t sts_i
);
  import lsev_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MXP, S_MC0, S_MC1, S_ACC, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q, out_valid_q, take, slot_free;

  assign take      = in_valid_i && in_ready_q;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_XP;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_we   = take && (in_op_i == OP_LOAD);
        cmd_o.eval_init = take && (in_op_i == OP_EVAL);
      end
      S_MXP: cmd_o.mul_en = 1'b1;
      S_MC0: begin
        cmd_o.t_en    = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_C0;
      end
      S_MC1: begin
        cmd_o.acc0_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_C1;
      end
      S_ACC: begin
        cmd_o.acc1_en = 1'b1;
        cmd_o.p_upd   = !sts_i.k_last && sts_i.k_zero;
        cmd_o.num_en  = !sts_i.k_last && !sts_i.k_zero;
      end
      S_DIV:  cmd_o.p_upd = sts_i.div_done;
      S_DONE: cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take && (in_op_i == OP_EVAL)) begin
            state_q    <= S_MXP;
            in_ready_q <= 1'b0;
          end
        end
        S_MXP: state_q <= S_MC0;
        S_MC0: state_q <= S_MC1;
        S_MC1: state_q <= S_ACC;
        S_ACC: begin
          if (sts_i.k_last) begin
            state_q <= S_DONE;
          end else if (sts_i.k_zero) begin
            state_q <= S_MXP;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: if (sts_i.div_done) state_q <= S_MXP;
        S_DONE: begin
          if (slot_free) begin
            in_ready_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/lsev_chk.sv =====
// Port-level checker for the Legendre series evaluator, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsev_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [lsev_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lsev_pkg::OutDataW-1:0] m_axis_tdata
);
  import lsev_pkg::*;

  `LSEV_ASSERT_IMP(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
  `LSEV_ASSERT_IMP(a_eval_busy, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_EVAL,
                   ##1 !s_axis_tready)
  `LSEV_ASSERT_IMP(a_load_free, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_LOAD,
                   ##1 s_axis_tready)
  `LSEV_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(m_axis_tvalid),
                   !$past(s_axis_tready))

endmodule

bind legendre_series_evaluator_core lsev_chk u_lsev_chk (.*);

// ===== dv/tb_legendre_series_evaluator_core.sv =====
// Testbench: directed table, then random load and evaluate phases
`timescale 1ns / 1ps
module tb_legendre_series_evaluator_core;
  import lsev_pkg::*;

  typedef struct packed {
    logic signed [47:0] small_sum;
    logic signed [47:0] large_sum;
  } sums_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic               cls;
    logic [4:0]         ord;
    logic signed [31:0] val;  // coefficient, or register data for ROW_CFG
    logic signed [31:0] cos;  // series argument, or register index for ROW_CFG
    sums_t              want;
  } row_t;

  localparam longint OneQ = 64'sd1 << 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic signed [31:0] coef_tab [2][32];
  bit                 written [2][32];
  int unsigned        cur_max_order = 31;
  bit                 cur_first_class = 0;
  sums_t              sums_q [$];
  int                 mismatches = 0;
  bit                 quiet_rx = 0;

  legendre_series_evaluator_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint div_round(longint num, longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic sums_t series_sums(logic signed [31:0] cos);
    longint x, p_prev, p_cur, p_next, t, num, acc0, acc1;
    sums_t r;
    x = clip(longint'(cos), -OneQ, OneQ);
    acc0 = 0;
    acc1 = 0;
    p_prev = 0;
    p_cur = OneQ;
    for (int k = 0; k <= cur_max_order; k++) begin
      acc0 += div_round(longint'(coef_tab[0][k]) * p_cur, OneQ);
      acc1 += div_round(longint'(coef_tab[1][k]) * p_cur, OneQ);
      if (k == 0) begin
        p_next = x;
      end else begin
        t = div_round(x * p_cur, OneQ);
        num = longint'(2 * k + 1) * t - longint'(k) * p_prev;
        p_next = clip(div_round(num, k + 1), -OneQ, OneQ);
      end
      p_prev = p_cur;
      p_cur = p_next;
    end
    acc0 = clip(acc0, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    acc1 = clip(acc1, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    if (cur_first_class) acc0 = 0;
    r.small_sum = acc0[47:0];
    r.large_sum = acc1[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    mismatches++;
  endtask

  // Receiver: random stall before each transfer, sometimes none at all
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      n = quiet_rx ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    sums_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (sums_q.size() == 0) begin
        report_mismatch("unexpected result transfer", m_axis_tdata[47:0], 48'd0);
      end else begin
        want = sums_q.pop_front();
        if (m_axis_tdata[47:0] !== want.small_sum)
          report_mismatch("small_class_sum", m_axis_tdata[47:0], want.small_sum);
        if (m_axis_tdata[95:48] !== want.large_sum)
          report_mismatch("large_class_sum", m_axis_tdata[95:48], want.large_sum);
      end
    end
  end

  task automatic send_item(op_e op, logic cls, logic [4:0] ord, logic signed [31:0] val,
                           logic signed [31:0] cos, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, cos, val, ord};
    s_axis_tuser  <= {cls, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_LOAD) begin
      coef_tab[cls][ord] = val;
      written[cls][ord] = 1;
    end else begin
      sums_q.push_back(series_sums(cos));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sums_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_ORDER) cur_max_order = data;
    else cur_first_class = data[0];
  endtask

  function automatic bit eval_ready();
    for (int k = 0; k <= cur_max_order; k++)
      if (!written[0][k] || !written[1][k]) return 0;
    return 1;
  endfunction

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_cos();
    case ($urandom_range(0, 7))
      0: return 32'sh4000_0000;
      1: return -32'sh4000_0000;
      2: return $urandom;
      3: return 32'sd0;
      default: return 32'($urandom_range(0, 1 << 31)) - 32'sh4000_0000;
    endcase
  endfunction

  row_t dir_rows [$];

  task automatic add_row(row_kind_e kind, op_e op, logic cls, logic [4:0] ord,
                         logic signed [31:0] val, logic signed [31:0] cos,
                         logic signed [47:0] ws = 0, logic signed [47:0] wl = 0);
    row_t r;
    r.kind = kind; r.op = op; r.cls = cls; r.ord = ord; r.val = val; r.cos = cos;
    r.want.small_sum = ws;
    r.want.large_sum = wl;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [4:0] ord;
    logic       cls;
    add_row(ROW_CFG, OP_LOAD, 0, 0, 0, CFG_MAX_ORDER);
    add_row(ROW_ITEM, OP_LOAD, 0, 0, 32'sh0001_0000, 0);
    add_row(ROW_ITEM, OP_LOAD, 1, 0, 32'sh8000_0000, 0);
    add_row(ROW_CHECKED, OP_EVAL, 0, 0, 0, 32'sd0, 48'sd65536, -48'sd2147483648);
    add_row(ROW_CHECKED, OP_EVAL, 0, 0, 0, 32'sh4000_0005, 48'sd65536, -48'sd2147483648);
    add_row(ROW_CHECKED, OP_EVAL, 1, 31, -1, 32'sh8000_0000, 48'sd65536, -48'sd2147483648);
    add_row(ROW_ITEM, OP_LOAD, 0, 0, 32'sh7fff_ffff, 0);
    add_row(ROW_ITEM, OP_LOAD, 1, 0, 32'sd0, 0);
    add_row(ROW_CHECKED, OP_EVAL, 0, 0, 0, 32'sh7fff_ffff, 48'sd2147483647, 48'sd0);
    add_row(ROW_CFG, OP_LOAD, 0, 0, 1, CFG_MAX_ORDER);
    add_row(ROW_CFG, OP_LOAD, 0, 0, 1, CFG_FIRST_CLASS);
    add_row(ROW_ITEM, OP_LOAD, 0, 1, 32'sh8000_0000, 0);
    add_row(ROW_ITEM, OP_LOAD, 1, 1, 32'sh0001_0000, 0);
    add_row(ROW_CHECKED, OP_EVAL, 0, 0, 0, 32'sh4000_0000, 48'sd0, 48'sd65536);
    add_row(ROW_CHECKED, OP_EVAL, 0, 0, 0, -32'sh4000_0000, 48'sd0, -48'sd65536);
    add_row(ROW_CFG, OP_LOAD, 0, 0, 0, CFG_FIRST_CLASS);
    add_row(ROW_ITEM, OP_EVAL, 0, 0, 0, 32'sh2000_0000);
    add_row(ROW_ITEM, OP_EVAL, 0, 0, 0, 32'shc123_4567);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(cfg_idx_e'(dir_rows[i].cos), dir_rows[i].val[4:0]);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].cls, dir_rows[i].ord, dir_rows[i].val,
                  dir_rows[i].cos, 1);
        if (dir_rows[i].kind == ROW_CHECKED) begin
          sums_q.pop_back();
          sums_q.push_back(dir_rows[i].want);
        end
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      bit gaps;
      drain();
      case (ph)
        0: begin write_reg(CFG_MAX_ORDER, 5'd31); write_reg(CFG_FIRST_CLASS, 5'b11110); end
        1: begin write_reg(CFG_MAX_ORDER, 5'd0);  write_reg(CFG_FIRST_CLASS, 5'b00001); end
        2: begin write_reg(CFG_MAX_ORDER, 5'd31); write_reg(CFG_FIRST_CLASS, 5'b00001); end
        default: begin
          write_reg(CFG_MAX_ORDER, 5'($urandom_range(0, 31)));
          write_reg(CFG_FIRST_CLASS, 5'($urandom));
        end
      endcase
      gaps = (ph != 3);
      quiet_rx = (ph == 3);
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(0, 9) < 4 && eval_ready()) begin
          send_item(OP_EVAL, 1'($urandom), 5'($urandom), $urandom, rand_cos(), gaps);
        end else begin
          ord = 5'($urandom);
          cls = 1'($urandom);
          for (int k = 0; k <= cur_max_order; k++)
            if (!written[1][k]) begin ord = 5'(k); cls = 1; end
          for (int k = 0; k <= cur_max_order; k++)
            if (!written[0][k]) begin ord = 5'(k); cls = 0; end
          send_item(OP_LOAD, cls, ord, rand_coeff(), $urandom, gaps);
        end
      end
    end

    drain();
    if (mismatches == 0 && sums_q.size() == 0) begin
      $display("legendre_series_evaluator_core verification clean");
    end else begin
      $display("legendre_series_evaluator_core verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("legendre_series_evaluator_core verification failed");
    $finish;
  end

endmodule
